// ----- design/fcq_pkg.sv -----
package fcq_pkg;

	// Fixed widths of the request and result words.
	localparam int REQ_W = 2;
	localparam int KEY_W = 16;
	localparam int PAY_W = 16;
	localparam int POS_W = 4;
	localparam int CNT_W = 5;

	// Defaults for the top-level parameters.
	localparam int DEPTH_DEF        = 16;
	localparam int KEY_BITS_DEF     = 16;
	localparam int PAYLOAD_BITS_DEF = 16;

	// Request codes. The remaining code is served by default arms.
	typedef enum logic [REQ_W-1:0] {
		REQ_INSERT = 2'd0,
		REQ_POP    = 2'd1,
		REQ_REMOVE = 2'd2
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SCAN,
		ST_SHIFT,
		ST_RESP
	} state_t;

	// One result word as handed from the sequencer to the output register.
	typedef struct packed {
		logic             hit;
		logic             full;
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
		logic [POS_W-1:0] pos;
		logic [CNT_W-1:0] count;
	} res_t;

endpackage

// ----- design/fcq_ram.sv -----
module fcq_ram #(
	parameter int DEPTH = fcq_pkg::DEPTH_DEF,
	parameter int DW    = fcq_pkg::KEY_BITS_DEF + fcq_pkg::PAYLOAD_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DW-1:0]            wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DW-1:0]            rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- design/fcq_ctrl.sv -----
module fcq_ctrl #(
	parameter int DEPTH        = fcq_pkg::DEPTH_DEF,
	parameter int KEY_BITS     = fcq_pkg::KEY_BITS_DEF,
	parameter int PAYLOAD_BITS = fcq_pkg::PAYLOAD_BITS_DEF,
	parameter int DW           = fcq_pkg::KEY_BITS_DEF + fcq_pkg::PAYLOAD_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [fcq_pkg::REQ_W-1:0]  req_type,
	input  logic [fcq_pkg::KEY_W-1:0]  job_key,
	input  logic [fcq_pkg::PAY_W-1:0]  payload_in,
	output logic                       res_valid,
	input  logic                       res_ready,
	output fcq_pkg::res_t              res,
	output logic                       mem_we,
	output logic [$clog2(DEPTH)-1:0]   mem_waddr,
	output logic [DW-1:0]              mem_wdata,
	output logic                       mem_re,
	output logic [$clog2(DEPTH)-1:0]   mem_raddr,
	input  logic [DW-1:0]              mem_rdata
);

	import fcq_pkg::*;

	localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
	localparam int PW = (PAYLOAD_BITS < PAY_W) ? PAYLOAD_BITS : PAY_W;
	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	state_t        state_q, state_d;
	req_t          req_q;
	logic [KW-1:0] key_q;
	logic [PW-1:0] pay_q;
	logic [IW-1:0] head_q, head_d;
	logic [IW-1:0] idx_q, idx_d;
	logic [CW-1:0] count_q, count_d;
	res_t          res_q, res_d;

	logic [KW-1:0] rkey;
	logic [PW-1:0] rpay;
	logic [CW-1:0] idx_ext;
	logic          match;

	// Physical slot of a logical position, wrapping round the ring.
	function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] base,
			input logic [IW-1:0] off);
		logic [IW:0] s;
		s = (IW+1)'(base) + (IW+1)'(off);
		if (s >= (IW+1)'(DEPTH)) begin
			s = s - (IW+1)'(DEPTH);
		end
		return s[IW-1:0];
	endfunction

	assign rkey    = mem_rdata[DW-1:PW];
	assign rpay    = mem_rdata[PW-1:0];
	assign idx_ext = CW'(idx_q);
	assign match   = (req_q == REQ_POP) || (rkey == key_q);

	always_comb begin
		res       = res_q;
		res.count = CNT_W'(count_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_q <= req_t'(req_type);
			key_q <= job_key[KW-1:0];
			pay_q <= PW'(payload_in);
		end
		idx_q <= idx_d;
		res_q <= res_d;
	end

	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		count_d   = count_q;
		idx_d     = idx_q;
		res_d     = res_q;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = slot_of(head_q, idx_q);
		mem_wdata = mem_rdata;
		mem_re    = 1'b0;
		mem_raddr = slot_of(head_q, idx_q + IW'(1));

		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_DISPATCH;
				end
			end

			ST_DISPATCH: begin
				res_d   = '0;
				state_d = ST_RESP;
				if (req_q == REQ_INSERT) begin
					if (count_q == CW'(DEPTH)) begin
						res_d.full = 1'b1;
					end else begin
						mem_we    = 1'b1;
						mem_waddr = slot_of(head_q, IW'(count_q));
						mem_wdata = {key_q, pay_q};
						res_d.hit = 1'b1;
						res_d.pos = POS_W'(count_q);
						count_d   = count_q + CW'(1);
					end
				end else if ((req_q == REQ_POP || req_q == REQ_REMOVE) &&
						count_q != '0) begin
					mem_re    = 1'b1;
					mem_raddr = head_q;
					idx_d     = '0;
					state_d   = ST_SCAN;
				end
			end

			ST_SCAN: begin
				if (match) begin
					res_d.hit     = 1'b1;
					res_d.key     = KEY_W'(rkey);
					res_d.payload = PAY_W'(rpay);
					res_d.pos     = POS_W'(idx_q);
					if (idx_q == '0) begin
						// The oldest entry leaves by advancing the head.
						head_d  = slot_of(head_q, IW'(1));
						count_d = count_q - CW'(1);
						state_d = ST_RESP;
					end else if (idx_ext + CW'(1) < count_q) begin
						mem_re  = 1'b1;
						state_d = ST_SHIFT;
					end else begin
						count_d = count_q - CW'(1);
						state_d = ST_RESP;
					end
				end else if (idx_ext + CW'(1) < count_q) begin
					mem_re = 1'b1;
					idx_d  = idx_q + IW'(1);
				end else begin
					state_d = ST_RESP;
				end
			end

			ST_SHIFT: begin
				// Read data holds the entry one place up; move it down.
				mem_we = 1'b1;
				if (idx_ext + CW'(2) < count_q) begin
					mem_re    = 1'b1;
					mem_raddr = slot_of(head_q, idx_q + IW'(2));
					idx_d     = idx_q + IW'(1);
				end else begin
					count_d = count_q - CW'(1);
					state_d = ST_RESP;
				end
			end

			ST_RESP: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- design/fifo_with_cancel_by_key_top.sv -----
// Channel | Handshake            | Word
// --------+----------------------+-------------------------------------------------
// request | in_valid / in_ready  | req_type, job_key, payload_in
// result  | out_valid / out_ready| hit, full_flag, key_out, payload_out,
//         |                      | position_out, count_out
//
// Every request word yields one result word. An insert, a miss on an empty queue or the
// unused code goes from dispatch straight to the response state; a pop takes the head;
// a remove scans until the key matches, then moves each later entry down, one memory
// read and one write per cycle. The next request is taken once the sequencer is idle.
// Reset clears the count, the ring head, the control state and the output valid, not the
// entries. One result waiting in the output register lets the next request in; a second
// finished result holds the sequencer, and with it the input, until that register frees.
module fifo_with_cancel_by_key_top #(
	parameter int DEPTH        = fcq_pkg::DEPTH_DEF,
	parameter int KEY_BITS     = fcq_pkg::KEY_BITS_DEF,
	parameter int PAYLOAD_BITS = fcq_pkg::PAYLOAD_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [fcq_pkg::REQ_W-1:0] req_type,
	input  logic [fcq_pkg::KEY_W-1:0] job_key,
	input  logic [fcq_pkg::PAY_W-1:0] payload_in,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      hit,
	output logic                      full_flag,
	output logic [fcq_pkg::KEY_W-1:0] key_out,
	output logic [fcq_pkg::PAY_W-1:0] payload_out,
	output logic [fcq_pkg::POS_W-1:0] position_out,
	output logic [fcq_pkg::CNT_W-1:0] count_out
);

	import fcq_pkg::*;

	// Keys wider than the request field carry only zeros above it, so the stored
	// key is never wider than the field. The payload follows the same reasoning.
	localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
	localparam int PW = (PAYLOAD_BITS < PAY_W) ? PAYLOAD_BITS : PAY_W;
	localparam int DW = KW + PW;
	localparam int IW = $clog2(DEPTH);

	logic          res_valid;
	logic          res_ready;
	res_t          res;
	logic          mem_we;
	logic [IW-1:0] mem_waddr;
	logic [DW-1:0] mem_wdata;
	logic          mem_re;
	logic [IW-1:0] mem_raddr;
	logic [DW-1:0] mem_rdata;
	logic          out_valid_q;
	res_t          out_q;

	// The entries live in a ring in one memory, each word holding key over payload.
	fcq_ram #(
		.DEPTH (DEPTH),
		.DW    (DW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// The sequencer scans the ring for a key and closes any gap one entry per cycle.
	fcq_ctrl #(
		.DEPTH        (DEPTH),
		.KEY_BITS     (KEY_BITS),
		.PAYLOAD_BITS (PAYLOAD_BITS),
		.DW           (DW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.job_key    (job_key),
		.payload_in (payload_in),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	// The output register takes a new word when it is empty or being emptied.
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign hit          = out_q.hit;
	assign full_flag    = out_q.full;
	assign key_out      = out_q.key;
	assign payload_out  = out_q.payload;
	assign position_out = out_q.pos;
	assign count_out    = out_q.count;

endmodule

// ----- dv/fcq_result_check.sv -----
module fcq_result_check (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic [fcq_pkg::REQ_W-1:0] req_type,
	input  logic [fcq_pkg::KEY_W-1:0] job_key,
	input  logic [fcq_pkg::PAY_W-1:0] payload_in,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  logic                      hit,
	input  logic                      full_flag,
	input  logic [fcq_pkg::KEY_W-1:0] key_out,
	input  logic [fcq_pkg::PAY_W-1:0] payload_out,
	input  logic [fcq_pkg::POS_W-1:0] position_out,
	input  logic [fcq_pkg::CNT_W-1:0] count_out,
	output int                        fail_count,
	output int                        words_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import fcq_pkg::*;

	// Shadow of the job queue, oldest entry at index 0.
	logic [KEY_W-1:0] job_keys [DEPTH_DEF];
	logic [PAY_W-1:0] job_payloads [DEPTH_DEF];
	int unsigned      job_total;

	// Result words still owed by the block, oldest first.
	res_t owed_words [$];

	task automatic report_mismatch(input string msg);
		fail_count++;
		$display("mismatch at %0t ns: %s", $realtime, msg);
	endtask

	// Unlink one entry and close the gap behind it.
	function automatic void unlink_job(input int unsigned slot);
		for (int unsigned i = slot; i + 1 < job_total; i++) begin
			job_keys[i]     = job_keys[i + 1];
			job_payloads[i] = job_payloads[i + 1];
		end
		job_total--;
	endfunction

	function automatic res_t serve_request(input logic [REQ_W-1:0] kind,
			input logic [KEY_W-1:0] key, input logic [PAY_W-1:0] pay);
		res_t word;
		word = '0;
		case (kind)
		REQ_INSERT: begin
			if (job_total >= DEPTH_DEF) begin
				word.full = 1'b1;
			end else begin
				job_keys[job_total]     = key;
				job_payloads[job_total] = pay;
				word.pos                = POS_W'(job_total);
				word.hit                = 1'b1;
				job_total++;
			end
		end
		REQ_POP: begin
			if (job_total > 0) begin
				word.key     = job_keys[0];
				word.payload = job_payloads[0];
				word.hit     = 1'b1;
				unlink_job(0);
			end
		end
		REQ_REMOVE: begin
			for (int unsigned i = 0; i < job_total; i++) begin
				if (job_keys[i] == key) begin
					word.key     = job_keys[i];
					word.payload = job_payloads[i];
					word.pos     = POS_W'(i);
					word.hit     = 1'b1;
					unlink_job(i);
					break;
				end
			end
		end
		default: ;
		endcase
		word.count = CNT_W'(job_total);
		return word;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			job_total = 0;
			owed_words.delete();
			fail_count = 0;
			words_pending = 0;
		end else begin
			if (in_valid && in_ready)
				owed_words.push_back(serve_request(req_type, job_key, payload_in));
			if (out_valid && out_ready) begin
				if (owed_words.size() == 0) begin
					report_mismatch("result word with no request outstanding");
				end else begin
					want = owed_words.pop_front();
					if (hit !== want.hit)
						report_mismatch($sformatf("hit %b, expected %b", hit, want.hit));
					if (full_flag !== want.full)
						report_mismatch($sformatf("full_flag %b, expected %b",
							full_flag, want.full));
					if (key_out !== want.key)
						report_mismatch($sformatf("key_out %h, expected %h",
							key_out, want.key));
					if (payload_out !== want.payload)
						report_mismatch($sformatf("payload_out %h, expected %h",
							payload_out, want.payload));
					if (position_out !== want.pos)
						report_mismatch($sformatf("position_out %0d, expected %0d",
							position_out, want.pos));
					if (count_out !== want.count)
						report_mismatch($sformatf("count_out %0d, expected %0d",
							count_out, want.count));
				end
			end
			words_pending = owed_words.size();
		end
	end

endmodule

// ----- dv/fifo_with_cancel_by_key_top_tb.sv -----
module fifo_with_cancel_by_key_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fcq_pkg::*;

	// The one request code that the block has no use for; it must be ignored.
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

	// Number of counted requests in each random phase.
	localparam int PHASE_WORDS    = 150;
	// How long the receiver refuses results when asked to hold off.
	localparam int HOLDOFF_CYCLES = 300;
	// Time allowed at the end for a worst-case remove, with a little on top.
	localparam int TAIL_CYCLES    = 2 * DEPTH_DEF + 10;
	// Roughly 650 words, each at worst a full scan plus long stalls, several times over.
	localparam int CYCLE_LIMIT    = 400000;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	logic [REQ_W-1:0] req_type;
	logic [KEY_W-1:0] job_key;
	logic [PAY_W-1:0] payload_in;
	logic             out_valid;
	logic             out_ready;
	logic             hit;
	logic             full_flag;
	logic [KEY_W-1:0] key_out;
	logic [PAY_W-1:0] payload_out;
	logic [POS_W-1:0] position_out;
	logic [CNT_W-1:0] count_out;

	int fail_count;
	int words_pending;

	// Percentages that shape the traffic; only the stimulus process writes them.
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	// The stimulus asks for a hold-off by bumping one counter, and the receiver
	// process answers by bumping its own, so that each has a single writer.
	int holdoff_asked  = 0;
	int holdoff_served = 0;

	int unsigned cycle_count = 0;

	fifo_with_cancel_by_key_top uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.job_key     (job_key),
		.payload_in  (payload_in),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.hit         (hit),
		.full_flag   (full_flag),
		.key_out     (key_out),
		.payload_out (payload_out),
		.position_out(position_out),
		.count_out   (count_out)
	);

	// The checker watches both channels, keeps its own copy of the queue and
	// compares every result word with what it has worked out.
	fcq_result_check result_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.job_key      (job_key),
		.payload_in   (payload_in),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.hit          (hit),
		.full_flag    (full_flag),
		.key_out      (key_out),
		.payload_out  (payload_out),
		.position_out (position_out),
		.count_out    (count_out),
		.fail_count   (fail_count),
		.words_pending(words_pending)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// A run that hangs is a failure in its own right.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Receiver side. Inputs change on the falling edge only, so the block and the
	// checker always see settled values at the rising edge. A hold-off keeps
	// out_ready low for a long stretch, counted here, while the sender carries on.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (holdoff_asked != holdoff_served) begin
				holdoff_served++;
				out_ready <= 1'b0;
				repeat (HOLDOFF_CYCLES - 1) @(negedge clk);
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// Offer one request word and hold it steady until the block takes it. The
	// task is entered and left on a falling edge. After acceptance the sender
	// may go quiet for a while; if it does not, the next call raises the next
	// word straight away, so in_valid is never dropped and raised in one step.
	task automatic offer_request(input logic [REQ_W-1:0] kind,
			input logic [KEY_W-1:0] key, input logic [PAY_W-1:0] pay);
		in_valid   <= 1'b1;
		req_type   <= kind;
		job_key    <= key;
		payload_in <= pay;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(negedge clk);
			while ($urandom_range(0, 99) < send_idle_pct);
		end
	endtask

	// Stop sending until every result word owed has come back.
	task automatic wait_for_quiet();
		in_valid <= 1'b0;
		while (words_pending != 0)
			@(negedge clk);
	endtask

	initial begin
		int               send_pct [4];
		int               recv_pct [4];
		int               counted;
		int unsigned      roll;
		logic [REQ_W-1:0] kind;
		logic [KEY_W-1:0] key;
		bit               filling;

		send_pct   = '{0, 78, 0, 16};
		recv_pct   = '{0, 0, 78, 16};
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		req_type   = REQ_INSERT;
		job_key    = '0;
		payload_in = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed opening. Nothing is queued yet, so a pop and a remove must
		// both miss, and the unused code must leave the queue alone.
		offer_request(REQ_POP, 16'h0000, 16'h0000);
		offer_request(REQ_REMOVE, 16'h0000, 16'h0000);
		offer_request(REQ_UNUSED, 16'hFFFF, 16'hFFFF);

		// Extreme keys and payloads, then a duplicate key: the remove must take
		// the older of the two, and a key that was never inserted must miss.
		offer_request(REQ_INSERT, 16'hFFFF, 16'h0000);
		offer_request(REQ_INSERT, 16'h0000, 16'hFFFF);
		offer_request(REQ_INSERT, 16'h0005, 16'h1234);
		offer_request(REQ_INSERT, 16'h0005, 16'h5678);
		offer_request(REQ_REMOVE, 16'h0005, 16'h0000);
		offer_request(REQ_REMOVE, 16'h1234, 16'h0000);
		offer_request(REQ_POP, 16'h0000, 16'h0000);

		// Two entries remain; fill the queue to the brim, then try one more
		// insert, which must be dropped and flagged as full.
		for (int i = 0; i < DEPTH_DEF - 2; i++)
			offer_request(REQ_INSERT, KEY_W'(16'h0100 + i), PAY_W'($urandom));
		offer_request(REQ_INSERT, 16'hABCD, 16'hDCBA);

		// Remove from the very back (longest scan) and from the very front.
		offer_request(REQ_REMOVE, KEY_W'(16'h0100 + DEPTH_DEF - 3), 16'h0000);
		offer_request(REQ_REMOVE, 16'h0000, 16'h0000);
		wait_for_quiet();

		// Random phases, each with its own idling mix. Keys come mostly from a
		// small pool so that removes hit and duplicates are common; a few reach
		// the top of the key range or are fully random. The bias between
		// inserting and draining swings every forty words so the queue both
		// empties and overflows.
		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct  = send_pct[phase];
			recv_stall_pct = recv_pct[phase];
			// In the phase with no idling, the receiver holds off for a long
			// stretch while words keep coming, so the block fills and stalls.
			if (phase == 0)
				holdoff_asked++;
			counted = 0;
			while (counted < PHASE_WORDS) begin
				filling = ((counted / 40) % 2) == 0;
				roll    = $urandom_range(0, 99);
				if (roll < 3)
					kind = REQ_UNUSED;
				else if (roll < (filling ? 70 : 35))
					kind = REQ_INSERT;
				else if (roll < (filling ? 82 : 65))
					kind = REQ_POP;
				else
					kind = REQ_REMOVE;

				roll = $urandom_range(0, 99);
				if (roll < 75)
					key = KEY_W'($urandom_range(0, 11));
				else if (roll < 85)
					key = 16'hFFFF - KEY_W'($urandom_range(0, 3));
				else
					key = KEY_W'($urandom);

				offer_request(kind, key, PAY_W'($urandom));
				if (kind != REQ_UNUSED)
					counted++;
			end
			// The sender pauses here until everything owed has come back.
			wait_for_quiet();
		end

		// Let the receiver take everything and give any stray word time to show.
		recv_stall_pct = 0;
		wait_for_quiet();
		repeat (TAIL_CYCLES) @(negedge clk);

		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
